// ----- rtl/core/bps_pkg.sv -----
package bps_pkg;

  localparam int PWM_RES           = 10;
  localparam int DEFAULT_GATE_FREQ = 2000;
  localparam int DUTY_W            = 10;
  localparam int PCT_W             = 7;
  localparam int PCT_MAX           = 100;

  // x / 100 as a multiply by a rounded-up reciprocal, exact for x < 2^23
  localparam int          RECIP_SHIFT = 32;
  localparam logic [63:0] RECIP       = ((64'd1 << RECIP_SHIFT) + 64'(PCT_MAX - 1)) / PCT_MAX;
  localparam logic [63:0] DUTY_MUL    = ((64'd1 << PWM_RES) - 64'd1) * RECIP;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_BEEP      = 3'd1,
    OP_BEEP_FREQ = 3'd2,
    OP_TWO_TONE  = 3'd3,
    OP_DOUBLE    = 3'd4,
    OP_STOP      = 3'd5
  } op_t;

  localparam logic [1:0] TT_WAIT   = 2'd0;
  localparam logic [1:0] TT_ARM    = 2'd1;
  localparam logic [1:0] TT_SECOND = 2'd2;

  localparam logic [1:0] DBL_IDLE   = 2'd0;
  localparam logic [1:0] DBL_FIRST  = 2'd1;
  localparam logic [1:0] DBL_GAP    = 2'd2;
  localparam logic [1:0] DBL_SECOND = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] first_duration_ms;
    logic [7:0]  first_duty_percent;
    logic [31:0] first_freq_hz;
    logic [31:0] second_freq_hz;
    logic [7:0]  second_duty_percent;
    logic [31:0] second_duration_ms;
    logic [15:0] gap_ms;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_level;
    logic [31:0]       gate_freq_hz;
    logic              active;
  } res_t;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic [31:0]       end_ms;
    logic              running;
    logic              two_tone_on;
    logic [1:0]        two_tone_phase;
    logic [31:0]       pending_freq;
    logic [PCT_W-1:0]  pending_duty;
    logic [31:0]       pending_dur;
    logic              double_on;
    logic [1:0]        double_stage;
    logic [15:0]       double_gap;
    logic [15:0]       double_second_on;
    logic [PCT_W-1:0]  double_duty;
    logic [DUTY_W-1:0] cur_duty;
    logic [31:0]       cur_freq;
  } state_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [7:0] pct);
    return (pct > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct[PCT_W-1:0];
  endfunction

  function automatic logic [DUTY_W-1:0] scale_duty(input logic [PCT_W-1:0] pct);
    logic [63:0] prod;
    prod = DUTY_MUL * 64'(pct);
    return prod[RECIP_SHIFT +: DUTY_W];
  endfunction

endpackage

// ----- rtl/core/bps_cmd_if.sv -----
interface bps_cmd_if import bps_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/bps_res_if.sv -----
interface bps_res_if import bps_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/beep_pattern_sequencer_core.sv -----
// channel | dir | payload                              | handshake
// cmd     | in  | operation, durations, duties, freqs  | valid / ready
// res     | out | duty_level, gate_freq_hz, active     | valid / ready
//
// one transaction per cycle sustained while no held result stalls; a command is taken into
// the input register, then goes through the step logic into the result register
// rst is synchronous: clears both stages and the sequencer state, gate frequency
// returns to the default; cmd.ready is low while rst is high
// a held result stalls the input register, which then holds cmd.ready low

module beep_pattern_sequencer_core import bps_pkg::*; (
  input logic      clk,
  input logic      rst,
  bps_cmd_if.sink  cmd,
  bps_res_if.source res
);

  logic   cmd_valid_q;
  cmd_t   cmd_q;
  logic   res_valid;
  res_t   res_q;
  state_t state;
  state_t state_next;
  state_t state_init;
  logic   advance;

  assign advance   = cmd_valid_q && (!res_valid || res.ready);
  assign cmd.ready = !rst && (!cmd_valid_q || advance);
  assign res.valid = res_valid;
  assign res.data  = res_q;

  always_comb begin
    state_init          = '0;
    state_init.cur_freq = 32'(DEFAULT_GATE_FREQ);
  end

  bps_step u_step (
    .st  (state),
    .cmd (cmd_q),
    .nx  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid_q <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_q <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q.duty_level   <= state_next.cur_duty;
      res_q.gate_freq_hz <= state_next.cur_freq;
      res_q.active       <= state_next.running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= state_init;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/core/bps_step.sv -----
module bps_step import bps_pkg::*; (
  input  state_t st,
  input  cmd_t   cmd,
  output state_t nx
);

  logic [PCT_W-1:0]  duty1;
  logic [PCT_W-1:0]  duty2;
  logic [PCT_W-1:0]  scale_pct;
  logic [DUTY_W-1:0] scaled;
  logic [31:0]       now_inc;
  logic              tt_arm;

  assign duty1   = clamp_pct(cmd.first_duty_percent);
  assign duty2   = clamp_pct(cmd.second_duty_percent);
  assign now_inc = st.now_ms + 32'd1;
  assign tt_arm  = st.two_tone_on && (st.two_tone_phase == TT_ARM);

  // one scaler shared by all paths
  always_comb begin
    if (op_t'(cmd.operation) == OP_TICK) begin
      scale_pct = tt_arm ? st.pending_duty : st.double_duty;
    end else begin
      scale_pct = duty1;
    end
  end

  assign scaled = scale_duty(scale_pct);

  always_comb begin
    nx = st;
    unique case (op_t'(cmd.operation))
      OP_TICK: begin
        nx.now_ms = now_inc;
        if (st.running && (now_inc >= st.end_ms)) begin
          if (st.two_tone_on && (st.two_tone_phase == TT_WAIT)) begin
            nx.two_tone_phase = TT_ARM;
          end else if (tt_arm) begin
            nx.cur_freq       = st.pending_freq;
            nx.cur_duty       = scaled;
            nx.end_ms         = now_inc + st.pending_dur;
            nx.two_tone_phase = TT_SECOND;
          end else begin
            nx.cur_duty    = '0;
            nx.running     = 1'b0;
            nx.two_tone_on = 1'b0;
            if (st.double_on) begin
              unique case (st.double_stage)
                DBL_FIRST: begin
                  nx.double_stage = DBL_GAP;
                  nx.end_ms       = now_inc + 32'(st.double_gap);
                  nx.running      = 1'b1;
                end
                DBL_GAP: begin
                  nx.double_stage = DBL_SECOND;
                  nx.cur_duty     = scaled;
                  nx.end_ms       = now_inc + 32'(st.double_second_on);
                  nx.running      = 1'b1;
                end
                DBL_SECOND: begin
                  nx.double_on    = 1'b0;
                  nx.double_stage = DBL_IDLE;
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      OP_BEEP: begin
        nx.cur_duty    = scaled;
        nx.running     = 1'b1;
        nx.end_ms      = st.now_ms + cmd.first_duration_ms;
        nx.two_tone_on = 1'b0;
      end
      OP_BEEP_FREQ: begin
        nx.cur_freq    = cmd.first_freq_hz;
        nx.cur_duty    = scaled;
        nx.running     = 1'b1;
        nx.end_ms      = st.now_ms + cmd.first_duration_ms;
        nx.two_tone_on = 1'b0;
      end
      OP_TWO_TONE: begin
        // zero first duration drops the whole command, the state stays unchanged
        if (cmd.first_duration_ms != '0) begin
          nx.cur_freq = cmd.first_freq_hz;
          nx.cur_duty = scaled;
          nx.running  = 1'b1;
          nx.end_ms   = st.now_ms + cmd.first_duration_ms;
          if (cmd.second_duration_ms != '0) begin
            nx.two_tone_on    = 1'b1;
            nx.two_tone_phase = TT_WAIT;
            nx.pending_freq   = cmd.second_freq_hz;
            nx.pending_duty   = duty2;
            nx.pending_dur    = cmd.second_duration_ms;
          end else begin
            nx.two_tone_on = 1'b0;
          end
        end
      end
      OP_DOUBLE: begin
        nx.double_on        = 1'b1;
        nx.double_stage     = DBL_FIRST;
        nx.double_gap       = cmd.gap_ms;
        nx.double_second_on = cmd.second_duration_ms[15:0];
        nx.double_duty      = duty1;
        nx.two_tone_on      = 1'b0;
        nx.cur_duty         = scaled;
        nx.running          = 1'b1;
        nx.end_ms           = st.now_ms + 32'(cmd.first_duration_ms[15:0]);
      end
      OP_STOP: begin
        nx.cur_duty = '0;
        nx.running  = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/sv/tb_beep_pattern_sequencer_core.sv -----
`timescale 1ns / 1ps

module tb_beep_pattern_sequencer_core;
  import bps_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;

  class buzzer_scoreboard;
    bit [31:0] clock_ms;
    bit [31:0] stop_ms;
    bit        tone_on;
    bit        chirp_on;
    bit [1:0]  chirp_phase;
    bit [31:0] chirp_freq;
    bit [6:0]  chirp_pct;
    bit [31:0] chirp_len;
    bit        pair_on;
    bit [1:0]  pair_stage;
    bit [15:0] pair_gap;
    bit [15:0] pair_len;
    bit [6:0]  pair_pct;
    bit [31:0] duty_now;
    bit [31:0] freq_now;
    res_t      buzzer_outputs_q[$];
    int        errors;

    function new();
      freq_now = DEFAULT_GATE_FREQ;
    endfunction

    function bit [6:0] limit_pct(bit [7:0] p);
      return (p > 8'd100) ? 7'd100 : p[6:0];
    endfunction

    function bit [31:0] pct_to_level(bit [6:0] p);
      bit [31:0] full;
      full = (32'd1 << PWM_RES) - 32'd1;
      return full * {25'd0, p} / 32'd100;
    endfunction

    // timer expiry on a tick: two-tone handoff or end of tone / double-beep stage
    function void advance_pattern();
      if (!tone_on || clock_ms < stop_ms) return;
      if (chirp_on && chirp_phase == TT_WAIT) begin
        chirp_phase = TT_ARM;
      end else if (chirp_on && chirp_phase == TT_ARM) begin
        freq_now = chirp_freq;
        duty_now = pct_to_level(chirp_pct);
        stop_ms = clock_ms + chirp_len;
        chirp_phase = TT_SECOND;
      end else begin
        duty_now = 0;
        tone_on = 1'b0;
        chirp_on = 1'b0;
        if (pair_on) begin
          case (pair_stage)
            DBL_FIRST: begin
              pair_stage = DBL_GAP;
              stop_ms = clock_ms + {16'd0, pair_gap};
              tone_on = 1'b1;
            end
            DBL_GAP: begin
              pair_stage = DBL_SECOND;
              duty_now = pct_to_level(pair_pct);
              stop_ms = clock_ms + {16'd0, pair_len};
              tone_on = 1'b1;
            end
            DBL_SECOND: begin
              pair_on = 1'b0;
              pair_stage = DBL_IDLE;
            end
            default: ;
          endcase
        end
      end
    endfunction

    function void take_command(cmd_t c);
      bit [6:0] p1;
      res_t     r;
      p1 = limit_pct(c.first_duty_percent);
      case (c.operation)
        OP_TICK: begin
          clock_ms = clock_ms + 32'd1;
          advance_pattern();
        end
        OP_BEEP: begin
          duty_now = pct_to_level(p1);
          tone_on = 1'b1;
          stop_ms = clock_ms + c.first_duration_ms;
          chirp_on = 1'b0;
        end
        OP_BEEP_FREQ: begin
          freq_now = c.first_freq_hz;
          duty_now = pct_to_level(p1);
          tone_on = 1'b1;
          chirp_on = 1'b0;
          stop_ms = clock_ms + c.first_duration_ms;
        end
        OP_TWO_TONE: begin
          // zero first duration drops the whole command
          if (c.first_duration_ms != 0) begin
            freq_now = c.first_freq_hz;
            duty_now = pct_to_level(p1);
            tone_on = 1'b1;
            stop_ms = clock_ms + c.first_duration_ms;
            if (c.second_duration_ms != 0) begin
              chirp_on = 1'b1;
              chirp_phase = TT_WAIT;
              chirp_freq = c.second_freq_hz;
              chirp_pct = limit_pct(c.second_duty_percent);
              chirp_len = c.second_duration_ms;
            end else begin
              chirp_on = 1'b0;
            end
          end
        end
        OP_DOUBLE: begin
          pair_on = 1'b1;
          pair_stage = DBL_FIRST;
          pair_gap = c.gap_ms;
          pair_len = c.second_duration_ms[15:0];
          pair_pct = p1;
          chirp_on = 1'b0;
          duty_now = pct_to_level(p1);
          tone_on = 1'b1;
          stop_ms = clock_ms + {16'd0, c.first_duration_ms[15:0]};
        end
        OP_STOP: begin
          duty_now = 0;
          tone_on = 1'b0;
        end
        default: ;
      endcase
      r.duty_level = duty_now[DUTY_W-1:0];
      r.gate_freq_hz = freq_now;
      r.active = tone_on;
      buzzer_outputs_q.push_back(r);
    endfunction

    function void check_output(res_t got);
      res_t want;
      if (buzzer_outputs_q.size() == 0) begin
        $display("%0t: unexpected result duty=%0d freq=%0d active=%0b", $time,
                 got.duty_level, got.gate_freq_hz, got.active);
        errors++;
        return;
      end
      want = buzzer_outputs_q.pop_front();
      if (got.duty_level !== want.duty_level) begin
        $display("%0t: duty_level expected %0d got %0d", $time, want.duty_level,
                 got.duty_level);
        errors++;
      end
      if (got.gate_freq_hz !== want.gate_freq_hz) begin
        $display("%0t: gate_freq_hz expected %0d got %0d", $time, want.gate_freq_hz,
                 got.gate_freq_hz);
        errors++;
      end
      if (got.active !== want.active) begin
        $display("%0t: active expected %0b got %0b", $time, want.active, got.active);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bps_cmd_if cmd_if();
  bps_res_if res_if();

  beep_pattern_sequencer_core dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  buzzer_scoreboard sb = new();
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned random_count;

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, logic [31:0] dur1, logic [7:0] duty1,
                                    logic [31:0] f1, logic [31:0] f2, logic [7:0] duty2,
                                    logic [31:0] dur2, logic [15:0] gap);
    cmd_t c;
    c.operation = op;
    c.first_duration_ms = dur1;
    c.first_duty_percent = duty1;
    c.first_freq_hz = f1;
    c.second_freq_hz = f2;
    c.second_duty_percent = duty2;
    c.second_duration_ms = dur2;
    c.gap_ms = gap;
    return c;
  endfunction

  function automatic logic [31:0] rand_dur();
    int unsigned r;
    logic [15:0] hi;
    r = $urandom_range(0, 99);
    hi = 16'($urandom);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 90) return {hi, 16'($urandom_range(0, 6))};
    return $urandom;
  endfunction

  function automatic logic [7:0] rand_duty();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 100));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cmd_t rand_cmd(logic [2:0] op);
    logic [15:0] gap;
    gap = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    return make_cmd(op, rand_dur(), rand_duty(), $urandom, $urandom, rand_duty(),
                    rand_dur(), gap);
  endfunction

  task automatic send_command(input cmd_t c);
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(30, 120);
      gap = pick_idle();
    end
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_command(rand_cmd(OP_TICK));
  endtask

  // a transaction on either side counts as progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && cmd_if.valid && cmd_if.ready) sb.take_command(cmd_if.data);
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_output(res_if.data);
  end

  initial begin
    int unsigned n;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
      n = pick_idle();
      if (n > 0) begin
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned r;
    logic [2:0] op;
    bit drained;
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    burst_left = 0;
    random_count = 0;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, each command, the corner cases
    send_ticks(1);
    send_command(make_cmd(OP_BEEP, 32'd2, 8'd0, 32'd0, 32'd0, 8'd0, 32'd0, 16'd0));
    send_ticks(2);
    send_command(make_cmd(OP_BEEP_FREQ, 32'd1, 8'd255, 32'd0, 32'hFFFF_FFFF, 8'd255,
                          32'hFFFF_FFFF, 16'hFFFF));
    send_ticks(1);
    // end time wraps around
    send_command(make_cmd(OP_BEEP_FREQ, 32'hFFFF_FFFF, 8'd100, 32'hFFFF_FFFF, 32'd0,
                          8'd0, 32'd0, 16'd0));
    send_ticks(1);
    // two-tone with zero first duration is dropped
    send_command(make_cmd(OP_TWO_TONE, 32'd0, 8'd60, 32'd999, 32'd888, 8'd40, 32'd3,
                          16'd0));
    // two-tone with zero second duration is a plain tone
    send_command(make_cmd(OP_TWO_TONE, 32'd1, 8'd101, 32'd777, 32'd555, 8'd20, 32'd0,
                          16'd0));
    send_ticks(1);
    send_command(make_cmd(OP_TWO_TONE, 32'd1, 8'd50, 32'd123, 32'd456, 8'd200, 32'd2,
                          16'd0));
    send_ticks(5);
    // double beep uses only the low half of the durations
    send_command(make_cmd(OP_DOUBLE, 32'h0001_0002, 8'd77, 32'd0, 32'd0, 8'd0,
                          32'hFFFF_0001, 16'd1));
    // stop does not cancel the double beep, the next tone resumes it
    send_command(make_cmd(OP_STOP, 32'd0, 8'd0, 32'd0, 32'd0, 8'd0, 32'd0, 16'd0));
    send_command(make_cmd(OP_BEEP, 32'd1, 8'd30, 32'd0, 32'd0, 8'd0, 32'd0, 16'd0));
    send_ticks(6);
    send_command(rand_cmd(OP_SPARE_A));
    send_command(rand_cmd(OP_SPARE_B));

    // random: a command followed by a run of ticks
    while (random_count < RANDOM_ITEMS) begin
      if (!drained && random_count >= RANDOM_ITEMS / 2) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.buzzer_outputs_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) op = OP_BEEP;
      else if (r < 16) op = OP_BEEP_FREQ;
      else if (r < 30) op = OP_TWO_TONE;
      else if (r < 44) op = OP_DOUBLE;
      else if (r < 52) op = OP_STOP;
      else if (r < 54) op = OP_SPARE_A;
      else if (r < 56) op = OP_SPARE_B;
      else op = OP_TICK;
      send_command(rand_cmd(op));
      if (op != OP_SPARE_A && op != OP_SPARE_B) random_count++;
      n_ticks_send: begin
        int unsigned k;
        k = $urandom_range(0, 12);
        send_ticks(k);
        random_count += k;
      end
    end

    cmd_if.valid <= 1'b0;
    while (sb.buzzer_outputs_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.buzzer_outputs_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.buzzer_outputs_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bps_pkg.sv
rtl/core/bps_cmd_if.sv
rtl/core/bps_res_if.sv
rtl/core/bps_step.sv
rtl/core/beep_pattern_sequencer_core.sv
tb/sv/tb_beep_pattern_sequencer_core.sv
